[rtl/cmmd_pkg.sv]
package cmmd_pkg;

  // Default sizes of the stores, in bytes.
  localparam int RAM_BYTES_DEF     = 2097152;
  localparam int SCRATCH_BYTES_DEF = 4096;
  localparam int SEGMENT_BYTES     = 65536;

  // Offsets into a store are carried at the width of the largest user window.
  localparam int OFS_W = 23;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  // Route codes of a result beat.
  localparam logic [2:0] ROUTE_RAM     = 3'd0;
  localparam logic [2:0] ROUTE_PAR     = 3'd1;
  localparam logic [2:0] ROUTE_SCRATCH = 3'd2;
  localparam logic [2:0] ROUTE_BIOS    = 3'd3;
  localparam logic [2:0] ROUTE_FWD     = 3'd4;
  localparam logic [2:0] ROUTE_ZERO    = 3'd5;
  localparam logic [2:0] ROUTE_NONE    = 3'd6;

  // Access size codes.
  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd2;

  // Operation codes.
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Machine version that opens the extra register windows.
  localparam logic [1:0] VERSION_TWO = 2'd2;
  localparam logic [1:0] VERSION_RESET = 2'd1;

  // Segment codes (address bits 31..16).
  localparam logic [15:0] SEG_EXP1     = 16'h1d00;
  localparam logic [15:0] SEG_PAR      = 16'h1f00;
  localparam logic [15:0] SEG_IO       = 16'h1f80;
  localparam logic [15:0] SEG_IO2      = 16'h1f90;
  localparam logic [15:0] SEG_KIO      = 16'hbf80;
  localparam logic [15:0] SEG_KIO2     = 16'hbf90;
  localparam logic [15:0] SEG_BIOS     = 16'hbfc0;
  localparam logic [15:0] SEG_ZERO     = 16'h1fc0;
  localparam logic [15:0] SEG_ZERO_MSK = 16'hffc0;

  // Kernel windows of main RAM, compared on address bits 31..23.
  localparam logic [8:0] KSEG0_TOP = 9'h100;
  localparam logic [8:0] KSEG1_TOP = 9'h140;

  typedef struct packed {
    logic        operation;
    logic [31:0] address;
    logic [1:0]  access_size;
    logic [31:0] write_data;
  } in_t;

  typedef struct packed {
    logic [2:0]  route;
    logic [31:0] read_data;
    logic        fwd_valid;
    logic        fwd_is_write;
    logic [31:0] fwd_address;
    logic [1:0]  fwd_size;
    logic [31:0] fwd_data;
  } out_t;

  // A classified access as it waits in the queue.
  typedef struct packed {
    logic [2:0]       route;
    logic             is_write;
    logic [1:0]       size;
    logic [OFS_W-1:0] offset;
    logic [31:0]      address;
    logic [31:0]      wdata;
  } desc_t;

endpackage

[rtl/cmmd_front.sv]
module cmmd_front #(
  parameter int RAM_BYTES = cmmd_pkg::RAM_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  cmmd_pkg::in_t   in_data,
  input  logic            cfg_write,
  input  logic [1:0]      cfg_data,
  input  logic            q_full,
  input  logic            busy,
  output logic            push,
  output cmmd_pkg::desc_t push_data
);
  import cmmd_pkg::*;

  logic [1:0] machine_version;

  // The user must write the version register only while the block is idle; the block itself does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      machine_version <= VERSION_RESET;
    end else if (cfg_write) begin
      machine_version <= cfg_data;
    end
  end

  assign in_stall = q_full || busy;
  assign push     = in_valid && !in_stall;

  // Classify the beat: route, store offset and masked write data.
  always_comb begin
    logic        wr;
    logic        v2;
    logic [1:0]  sz;
    logic [31:0] mask;
    logic [31:0] aligned;
    logic [15:0] seg;
    logic [2:0]  route;
    logic [OFS_W-1:0] ofs;

    wr  = (in_data.operation == OP_WRITE);
    v2  = (machine_version == VERSION_TWO);
    sz  = (in_data.access_size > SIZE_WORD) ? SIZE_WORD : in_data.access_size;
    seg = in_data.address[31:16];

    case (sz)
      SIZE_BYTE: begin
        mask    = 32'h0000_00ff;
        aligned = in_data.address;
      end
      SIZE_HALF: begin
        mask    = 32'h0000_ffff;
        aligned = {in_data.address[31:1], 1'b0};
      end
      default: begin
        mask    = 32'hffff_ffff;
        aligned = {in_data.address[31:2], 2'b00};
      end
    endcase

    ofs = {7'd0, aligned[15:0]};

    if (seg == SEG_EXP1) begin
      // Writes reach the expansion port only in its first 128 bytes.
      route = (!wr || (in_data.address[15:7] == 9'd0)) ? ROUTE_FWD : ROUTE_NONE;
    end else if (seg == SEG_IO) begin
      route = (in_data.address[15:12] == 4'd0) ? ROUTE_SCRATCH : ROUTE_FWD;
    end else if (seg == SEG_IO2 && (wr || v2)) begin
      route = ROUTE_FWD;
    end else if ((seg == SEG_KIO || seg == SEG_KIO2) && v2) begin
      route = ROUTE_FWD;
    end else if (!wr && ((seg & SEG_ZERO_MSK) == SEG_ZERO)) begin
      route = ROUTE_ZERO;
    end else if (aligned[31:23] == 9'd0) begin
      route = ROUTE_RAM;
      ofs   = aligned[OFS_W-1:0];
    end else if ((aligned[31:23] == KSEG0_TOP || aligned[31:23] == KSEG1_TOP)
                 && ({1'b0, aligned[OFS_W-1:0]} < (OFS_W+1)'(RAM_BYTES))) begin
      route = ROUTE_RAM;
      ofs   = aligned[OFS_W-1:0];
    end else if (seg == SEG_PAR) begin
      route = ROUTE_PAR;
    end else if (seg == SEG_BIOS) begin
      route = ROUTE_BIOS;
    end else begin
      route = ROUTE_NONE;
    end

    push_data.route    = route;
    push_data.is_write = wr;
    push_data.size     = sz;
    push_data.offset   = ofs;
    push_data.address  = in_data.address;
    push_data.wdata    = in_data.write_data & mask;
  end

endmodule

[rtl/cmmd_queue.sv]
module cmmd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  cmmd_pkg::desc_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output cmmd_pkg::desc_t head
);
  import cmmd_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  desc_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full       = (count == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

[rtl/cmmd_back.sv]
module cmmd_back #(
  parameter int RAM_BYTES     = cmmd_pkg::RAM_BYTES_DEF,
  parameter int SCRATCH_BYTES = cmmd_pkg::SCRATCH_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  cmmd_pkg::desc_t head,
  output logic            pop,
  output logic            busy,
  output logic            out_valid,
  input  logic            out_stall,
  output cmmd_pkg::out_t  out_data
);
  import cmmd_pkg::*;

  localparam int RAM_ROWS   = RAM_BYTES / 4;
  localparam int SCR_ROWS   = SCRATCH_BYTES / 4;
  localparam int SEG_ROWS   = SEGMENT_BYTES / 4;
  localparam int RAM_AW     = $clog2(RAM_ROWS);
  localparam int SCR_AW     = $clog2(SCR_ROWS);
  localparam int SEG_AW     = $clog2(SEG_ROWS);
  localparam int CLEAR_ROWS = (RAM_ROWS > SEG_ROWS) ? RAM_ROWS : SEG_ROWS;
  localparam int CLEAR_AW   = $clog2(CLEAR_ROWS);

  logic [31:0] ram_mem  [RAM_ROWS];
  logic [31:0] par_mem  [SEG_ROWS];
  logic [31:0] scr_mem  [SCR_ROWS];
  logic [31:0] bios_mem [SEG_ROWS];

  logic [31:0] ram_q;
  logic [31:0] par_q;
  logic [31:0] scr_q;
  logic [31:0] bios_q;

  logic [CLEAR_AW-1:0] clear_row;
  desc_t               cur;
  logic [3:0]          lane_en;
  logic [31:0]         lane_data;
  logic                do_write;
  logic [RAM_AW-1:0]   ram_row;
  logic [SEG_AW-1:0]   seg_row;
  logic [SCR_AW-1:0]   scr_row;

  // Zeroing sweep after reset, one row of every store per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b1;
      clear_row <= '0;
    end else if (busy) begin
      if (clear_row == CLEAR_AW'(CLEAR_ROWS - 1)) begin
        busy <= 1'b0;
      end
      clear_row <= clear_row + 1'b1;
    end
  end

  // Take the next beat when the output register is free or being drained.
  assign pop = head_valid && !busy && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  // Byte lanes of the row touched by the head beat.
  always_comb begin
    case (head.size)
      SIZE_BYTE: lane_en = 4'b0001 << head.offset[1:0];
      SIZE_HALF: lane_en = head.offset[1] ? 4'b1100 : 4'b0011;
      default:   lane_en = 4'b1111;
    endcase
  end

  assign lane_data = head.wdata << {head.offset[1:0], 3'b000};
  assign do_write  = pop && head.is_write;
  assign ram_row   = head.offset[RAM_AW+1:2];
  assign seg_row   = head.offset[SEG_AW+1:2];
  assign scr_row   = head.offset[SCR_AW+1:2];

  // Main RAM.
  always_ff @(posedge clk) begin
    if (busy) begin
      ram_mem[clear_row[RAM_AW-1:0]] <= '0;
    end else if (do_write && head.route == ROUTE_RAM) begin
      for (int i = 0; i < 4; i++) begin
        if (lane_en[i]) begin
          ram_mem[ram_row][8*i +: 8] <= lane_data[8*i +: 8];
        end
      end
    end
    if (pop) begin
      ram_q <= ram_mem[ram_row];
    end
  end

  // Parallel-port store.
  always_ff @(posedge clk) begin
    if (busy) begin
      par_mem[clear_row[SEG_AW-1:0]] <= '0;
    end else if (do_write && head.route == ROUTE_PAR) begin
      for (int i = 0; i < 4; i++) begin
        if (lane_en[i]) begin
          par_mem[seg_row][8*i +: 8] <= lane_data[8*i +: 8];
        end
      end
    end
    if (pop) begin
      par_q <= par_mem[seg_row];
    end
  end

  // Scratch area.
  always_ff @(posedge clk) begin
    if (busy) begin
      scr_mem[clear_row[SCR_AW-1:0]] <= '0;
    end else if (do_write && head.route == ROUTE_SCRATCH) begin
      for (int i = 0; i < 4; i++) begin
        if (lane_en[i]) begin
          scr_mem[scr_row][8*i +: 8] <= lane_data[8*i +: 8];
        end
      end
    end
    if (pop) begin
      scr_q <= scr_mem[scr_row];
    end
  end

  // BIOS store.
  always_ff @(posedge clk) begin
    if (busy) begin
      bios_mem[clear_row[SEG_AW-1:0]] <= '0;
    end else if (do_write && head.route == ROUTE_BIOS) begin
      for (int i = 0; i < 4; i++) begin
        if (lane_en[i]) begin
          bios_mem[seg_row][8*i +: 8] <= lane_data[8*i +: 8];
        end
      end
    end
    if (pop) begin
      bios_q <= bios_mem[seg_row];
    end
  end

  // Format the result beat from the registered row and descriptor.
  always_comb begin
    logic [31:0] word;
    logic [31:0] shifted;
    logic [31:0] mask;
    logic        fwd;

    case (cur.route)
      ROUTE_RAM:     word = ram_q;
      ROUTE_PAR:     word = par_q;
      ROUTE_SCRATCH: word = scr_q;
      ROUTE_BIOS:    word = bios_q;
      default:       word = '0;
    endcase

    case (cur.size)
      SIZE_BYTE: mask = 32'h0000_00ff;
      SIZE_HALF: mask = 32'h0000_ffff;
      default:   mask = 32'hffff_ffff;
    endcase

    shifted = (word >> {cur.offset[1:0], 3'b000}) & mask;
    fwd     = (cur.route == ROUTE_FWD);

    out_data.route        = cur.route;
    out_data.read_data    = cur.is_write ? '0 : shifted;
    out_data.fwd_valid    = fwd;
    out_data.fwd_is_write = fwd && cur.is_write;
    out_data.fwd_address  = fwd ? cur.address : '0;
    out_data.fwd_size     = fwd ? cur.size : '0;
    out_data.fwd_data     = (fwd && cur.is_write) ? cur.wdata : '0;
  end

endmodule

[rtl/console_memory_map_decoder_unit.sv]
// Memory-map decoder for a console CPU bus. Each input beat is one read or
// write of a byte, halfword or word; it is classified by its 64 KiB segment
// and either carried out on one of the internal stores (main RAM, parallel
// port, scratch, BIOS), handed to external hardware registers through the
// fwd_* fields, read as zero or dropped. Outside the clearing sweep and while
// out_stall is low the block takes one beat per cycle; each beat passes the queue
// between the classifier and the execution stage, then the registered
// read of the single-port, word-wide store memories. After reset every store
// is zeroed by a sweep over max(RAM_BYTES/4, 16384) rows (524288 at the
// default RAM size) during which in_stall stays high; configuration writes
// are taken as usual. RAM_BYTES and SCRATCH_BYTES must be powers of two.
module console_memory_map_decoder_unit #(
  parameter int RAM_BYTES     = cmmd_pkg::RAM_BYTES_DEF,
  parameter int SCRATCH_BYTES = cmmd_pkg::SCRATCH_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  cmmd_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output cmmd_pkg::out_t  out_data,
  input  logic            cfg_write,
  input  logic [1:0]      cfg_data
);
  import cmmd_pkg::*;

  logic  push;
  desc_t push_data;
  logic  q_full;
  logic  pop;
  logic  head_valid;
  desc_t head;
  logic  busy;

  cmmd_front #(
    .RAM_BYTES (RAM_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .busy      (busy),
    .push      (push),
    .push_data (push_data)
  );

  cmmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  cmmd_back #(
    .RAM_BYTES     (RAM_BYTES),
    .SCRATCH_BYTES (SCRATCH_BYTES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .busy       (busy),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

`ifndef NO_ASSERTIONS
  // No beat is taken while the stores are being zeroed.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> in_stall)
    else $error("input beat accepted during the clearing sweep");

  // Only store routes can return nonzero read data.
  a_read_route: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.read_data != '0) |->
      (out_data.route == ROUTE_RAM || out_data.route == ROUTE_PAR ||
       out_data.route == ROUTE_SCRATCH || out_data.route == ROUTE_BIOS))
    else $error("nonzero read data on a non-store route");

  // A result appears only after a beat left the queue.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(pop))
    else $error("result beat without a popped queue entry");
`endif

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import cmmd_pkg::*;

  // Address map constants used by the predictor and the traffic generator.
  localparam logic [31:0] RAM_SIZE        = RAM_BYTES_DEF;
  localparam logic [31:0] SCRATCH_SIZE    = SCRATCH_BYTES_DEF;
  localparam logic [31:0] SEG_SIZE        = SEGMENT_BYTES;
  localparam logic [31:0] USER_WINDOW_TOP = 32'h0080_0000;
  localparam logic [31:0] KSEG0_BASE      = 32'h8000_0000;
  localparam logic [31:0] KSEG1_BASE      = 32'ha000_0000;
  localparam logic [31:0] SCRATCH_BASE    = 32'h1f80_0000;
  localparam logic [31:0] IO_REG_BASE     = 32'h1f80_1000;
  localparam logic [15:0] SEG_ZERO_LAST   = 16'h1fff;

  // Size code 3 is outside the encoding and behaves as a word.
  localparam logic [1:0] SIZE_SPARE = 2'd3;

  // Machine versions without their own meaning; both behave as the reset one.
  localparam logic [1:0] VERSION_LOW  = 2'd0;
  localparam logic [1:0] VERSION_HIGH = 2'd3;

  // Every store lives in one flat byte image, at these offsets.
  localparam int PAR_REGION     = RAM_BYTES_DEF;
  localparam int SCRATCH_REGION = PAR_REGION + SEGMENT_BYTES;
  localparam int BIOS_REGION    = SCRATCH_REGION + SCRATCH_BYTES_DEF;
  localparam int IMAGE_BYTES    = BIOS_REGION + SEGMENT_BYTES;

  // Run control. The idle limit covers the store clearing sweep after reset.
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES  = 8;
  localparam int PHASE_ITEMS   = 250;
  localparam int IDLE_LIMIT    = 2_000_000;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  in_t         in_data;
  logic        out_valid;
  logic        out_stall;
  out_t        out_data;
  logic        cfg_write;
  logic [1:0]  cfg_data;

  // Shadow state of the decoder.
  bit   [7:0]  store_image [IMAGE_BYTES];
  logic [1:0]  machine_version = VERSION_RESET;
  out_t        expected_results [$];
  int          error_count = 0;
  int          idle_cycles = 0;

  console_memory_map_decoder_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Decode one access, apply it to the shadow stores and return its result.
  function automatic out_t predict_access(in_t acc);
    out_t        res;
    logic [1:0]  size_code;
    logic [31:0] nbytes;
    logic [31:0] mask;
    logic [31:0] aligned;
    logic [31:0] wdata;
    logic [31:0] ofs;
    logic [15:0] seg;
    logic [2:0]  route;
    bit          is_wr;
    bit          v2;
    bit          fwd;
    int          region;
    int          span;
    int          idx;
    int          i;
    res       = '0;
    size_code = (acc.access_size > SIZE_WORD) ? SIZE_WORD : acc.access_size;
    nbytes    = 32'd1 << size_code;
    mask      = (size_code == SIZE_WORD) ? 32'hffff_ffff : (32'd1 << (8 * nbytes)) - 1;
    aligned   = acc.address & ~(nbytes - 1);
    wdata     = acc.write_data & mask;
    seg       = acc.address[31:16];
    is_wr     = acc.operation == OP_WRITE;
    v2        = machine_version == VERSION_TWO;
    fwd       = 1'b0;
    route     = ROUTE_NONE;
    ofs       = '0;

    // Register windows and the zero-read range take priority over the stores.
    if (seg == SEG_EXP1) begin
      fwd = !is_wr || acc.address[15:7] == '0;
    end else if (seg == SEG_IO) begin
      if (acc.address < IO_REG_BASE) begin
        route = ROUTE_SCRATCH;
        ofs   = aligned[15:0] % SCRATCH_SIZE;
      end else begin
        fwd = 1'b1;
      end
    end else if (seg == SEG_IO2 && (is_wr || v2)) begin
      fwd = 1'b1;
    end else if ((seg == SEG_KIO || seg == SEG_KIO2) && v2) begin
      fwd = 1'b1;
    end else if (!is_wr && (seg & SEG_ZERO_MSK) == SEG_ZERO) begin
      route = ROUTE_ZERO;
    end else if (aligned < USER_WINDOW_TOP) begin
      // The user window mirrors main RAM four times.
      route = ROUTE_RAM;
      ofs   = aligned % RAM_SIZE;
    end else if (aligned >= KSEG0_BASE && aligned - KSEG0_BASE < RAM_SIZE) begin
      route = ROUTE_RAM;
      ofs   = aligned - KSEG0_BASE;
    end else if (aligned >= KSEG1_BASE && aligned - KSEG1_BASE < RAM_SIZE) begin
      route = ROUTE_RAM;
      ofs   = aligned - KSEG1_BASE;
    end else if (seg == SEG_PAR) begin
      route = ROUTE_PAR;
      ofs   = aligned[15:0];
    end else if (seg == SEG_BIOS) begin
      route = ROUTE_BIOS;
      ofs   = aligned[15:0];
    end
    if (fwd) begin
      route = ROUTE_FWD;
    end

    // Little-endian byte access; each byte index wraps within its store.
    region = -1;
    span   = 1;
    case (route)
      ROUTE_RAM: begin
        region = 0;
        span   = RAM_BYTES_DEF;
      end
      ROUTE_PAR: begin
        region = PAR_REGION;
        span   = SEGMENT_BYTES;
      end
      ROUTE_SCRATCH: begin
        region = SCRATCH_REGION;
        span   = SCRATCH_BYTES_DEF;
      end
      ROUTE_BIOS: begin
        region = BIOS_REGION;
        span   = SEGMENT_BYTES;
      end
      default: begin
        region = -1;
      end
    endcase
    if (region >= 0) begin
      for (i = 0; i < nbytes; i++) begin
        idx = region + (ofs + i) % span;
        if (is_wr) begin
          store_image[idx] = wdata[8*i +: 8];
        end else begin
          res.read_data[8*i +: 8] = store_image[idx];
        end
      end
    end

    res.route        = route;
    res.fwd_valid    = fwd;
    res.fwd_is_write = fwd && is_wr;
    res.fwd_address  = fwd ? acc.address : '0;
    res.fwd_size     = fwd ? size_code : '0;
    res.fwd_data     = (fwd && is_wr) ? wdata : '0;
    return res;
  endfunction

  function automatic in_t bus_access(logic op, logic [31:0] addr, logic [1:0] size,
                                     logic [31:0] data);
    in_t acc;
    acc.operation   = op;
    acc.address     = addr;
    acc.access_size = size;
    acc.write_data  = data;
    return acc;
  endfunction

  // Offsets cluster at both ends of a region so that reads meet earlier writes.
  function automatic logic [31:0] hot_offset(logic [31:0] span);
    case ($urandom_range(0, 3))
      0: begin
        return $urandom_range(0, 63);
      end
      1: begin
        return span - 1 - $urandom_range(0, 63);
      end
      2: begin
        return $urandom_range(0, 1023);
      end
      default: begin
        return $urandom % span;
      end
    endcase
  endfunction

  function automatic in_t make_random_access();
    in_t         acc;
    logic [31:0] ofs;
    logic [31:0] edge_addr;
    acc.operation   = ($urandom_range(0, 99) < 45) ? OP_WRITE : OP_READ;
    acc.access_size = 2'($urandom_range(0, 3));
    acc.write_data  = $urandom;
    case ($urandom_range(0, 15))
      0, 1, 2, 3: begin
        ofs = hot_offset(RAM_SIZE);
        case ($urandom_range(0, 5))
          4: begin
            acc.address = KSEG0_BASE + ofs;
          end
          5: begin
            acc.address = KSEG1_BASE + ofs;
          end
          default: begin
            acc.address = $urandom_range(0, 3) * RAM_SIZE + ofs;
          end
        endcase
      end
      4: begin
        acc.address = {SEG_PAR, 16'(hot_offset(SEG_SIZE))};
      end
      5: begin
        acc.address = {SEG_BIOS, 16'(hot_offset(SEG_SIZE))};
      end
      6, 7: begin
        acc.address = SCRATCH_BASE + hot_offset(SCRATCH_SIZE);
      end
      8: begin
        acc.address = IO_REG_BASE + $urandom_range(0, 32'h0000_efff);
      end
      9: begin
        acc.address = {SEG_EXP1, ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 127))
                                                            : 16'($urandom)};
      end
      10: begin
        acc.address = {SEG_IO2, 16'($urandom)};
      end
      11: begin
        acc.address = {($urandom_range(0, 1) == 0) ? SEG_KIO : SEG_KIO2, 16'($urandom)};
      end
      12: begin
        acc.address = {16'($urandom_range(SEG_ZERO, SEG_ZERO_LAST)), 16'($urandom)};
      end
      13: begin
        // Just around the ends of the RAM windows.
        case ($urandom_range(0, 4))
          0: begin
            edge_addr = USER_WINDOW_TOP;
          end
          1: begin
            edge_addr = KSEG0_BASE;
          end
          2: begin
            edge_addr = KSEG0_BASE + RAM_SIZE;
          end
          3: begin
            edge_addr = KSEG1_BASE;
          end
          default: begin
            edge_addr = KSEG1_BASE + RAM_SIZE;
          end
        endcase
        acc.address = edge_addr - 8 + $urandom_range(0, 15);
      end
      default: begin
        acc.address = $urandom;
      end
    endcase
    return acc;
  endfunction

  // Present one input beat and hold it until the block takes it.
  task automatic send_access(input in_t acc);
    in_valid <= 1'b1;
    in_data  <= acc;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    expected_results.push_back(predict_access(acc));
  endtask

  // Drain the block, then write the version register.
  task automatic set_machine_version(input logic [1:0] version);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= version;
    @(posedge clk);
    cfg_write <= 1'b0;
    machine_version = version;
  endtask

  // Directed accesses at the edges of every store and window, reset version.
  task automatic test_store_windows();
    send_access(bus_access(OP_WRITE, 32'h0000_0000, SIZE_WORD, 32'hdead_beef));
    send_access(bus_access(OP_READ,  32'h0060_0000, SIZE_WORD, '0));
    send_access(bus_access(OP_READ,  32'h8000_0003, SIZE_BYTE, '0));
    send_access(bus_access(OP_READ,  32'ha000_0003, SIZE_HALF, '0));
    send_access(bus_access(OP_WRITE, 32'h007f_ffff, SIZE_BYTE, 32'hffff_ffff));
    send_access(bus_access(OP_READ,  32'h801f_fffc, SIZE_SPARE, '0));
    send_access(bus_access(OP_WRITE, 32'h1f00_fffe, SIZE_HALF, 32'h1234_5678));
    send_access(bus_access(OP_READ,  32'h1f00_fffc, SIZE_WORD, '0));
    send_access(bus_access(OP_WRITE, 32'h1f80_0ffc, SIZE_WORD, 32'h0bad_f00d));
    send_access(bus_access(OP_READ,  32'h1f80_0fff, SIZE_HALF, '0));
    send_access(bus_access(OP_WRITE, 32'h1f80_1000, SIZE_WORD, 32'hffff_ffff));
    send_access(bus_access(OP_WRITE, 32'hbfc0_fffc, SIZE_WORD, 32'hcafe_f00d));
    send_access(bus_access(OP_READ,  32'hbfc0_fffe, SIZE_HALF, '0));
    send_access(bus_access(OP_READ,  32'h1fc0_0000, SIZE_WORD, '0));
    send_access(bus_access(OP_READ,  32'h1fff_ffff, SIZE_BYTE, '0));
    send_access(bus_access(OP_WRITE, 32'h1fc0_0000, SIZE_WORD, 32'h5555_5555));
    send_access(bus_access(OP_WRITE, 32'h1d00_007f, SIZE_BYTE, 32'h8765_4321));
    send_access(bus_access(OP_WRITE, 32'h1d00_0080, SIZE_WORD, 32'h8765_4321));
    send_access(bus_access(OP_READ,  32'h1d00_ff00, SIZE_HALF, '0));
    send_access(bus_access(OP_READ,  32'h1f90_0000, SIZE_WORD, '0));
    send_access(bus_access(OP_WRITE, 32'h1f90_0004, SIZE_HALF, 32'hffff_0001));
    send_access(bus_access(OP_READ,  32'hbf80_0000, SIZE_WORD, '0));
    send_access(bus_access(OP_READ,  32'h8020_0000, SIZE_WORD, '0));
  endtask

  // The extra register windows open only at version two.
  task automatic test_register_windows();
    set_machine_version(VERSION_TWO);
    send_access(bus_access(OP_READ,  32'h1f90_0010, SIZE_WORD, '0));
    send_access(bus_access(OP_READ,  32'hbf80_fffc, SIZE_WORD, '0));
    send_access(bus_access(OP_WRITE, 32'hbf90_0000, SIZE_BYTE, 32'ha5a5_a5a5));
    set_machine_version(VERSION_HIGH);
    send_access(bus_access(OP_READ,  32'h1f90_0010, SIZE_WORD, '0));
    send_access(bus_access(OP_WRITE, 32'hbf80_0000, SIZE_WORD, 32'h0123_4567));
  endtask

  // Random traffic in bursts, one phase per version setting.
  task automatic test_random_traffic();
    logic [1:0] phase_versions [8] = '{VERSION_LOW, VERSION_TWO, VERSION_RESET, VERSION_TWO,
                                       VERSION_HIGH, VERSION_TWO, VERSION_LOW, VERSION_TWO};
    int         burst_left;
    int         gap;
    int         k;
    burst_left = 0;
    foreach (phase_versions[p]) begin
      set_machine_version(phase_versions[p]);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 60);
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
        send_access(make_random_access());
        burst_left--;
      end
    end
  endtask

  // Receiver stall pattern: modes of random length, one of them stall free.
  initial begin : result_stall
    stall_mode_e stall_mode;
    int          mode_left;
    int          tick;
    stall_mode = STALL_NONE;
    mode_left  = 0;
    tick       = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        mode_left  = $urandom_range(20, 200);
      end
      mode_left--;
      case (stall_mode)
        STALL_LIGHT: begin
          out_stall <= $urandom_range(0, 3) == 0;
        end
        STALL_HEAVY: begin
          out_stall <= $urandom_range(0, 3) != 0;
        end
        STALL_PERIODIC: begin
          out_stall <= (tick % 3) == 0;
        end
        default: begin
          out_stall <= 1'b0;
        end
      endcase
    end
  end

  function automatic int check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // Compare every result beat with the oldest expectation.
  always @(posedge clk) begin : result_check
    out_t want;
    int   bad;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %h", $time, out_data);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        bad  = 0;
        bad += check_field("route", want.route, out_data.route);
        bad += check_field("read_data", want.read_data, out_data.read_data);
        bad += check_field("fwd_valid", want.fwd_valid, out_data.fwd_valid);
        bad += check_field("fwd_is_write", want.fwd_is_write, out_data.fwd_is_write);
        bad += check_field("fwd_address", want.fwd_address, out_data.fwd_address);
        bad += check_field("fwd_size", want.fwd_size, out_data.fwd_size);
        bad += check_field("fwd_data", want.fwd_data, out_data.fwd_data);
        if (bad != 0) begin
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Reset, run the tests in turn, drain and report.
  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_write <= 1'b0;
    cfg_data  <= VERSION_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_store_windows();
    test_register_windows();
    test_random_traffic();

    in_valid <= 1'b0;
    while (expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
